/* hw/rtl/lcdseq_pkg.sv */
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types and codes of the character display bus sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

	// request codes
	localparam logic [1:0] OP_CMD  = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_INIT = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_BUS_FOUR_BIT       = 3'd0;
	localparam logic [2:0] CFG_TWO_LINES          = 3'd1;
	localparam logic [2:0] CFG_TALL_FONT          = 3'd2;
	localparam logic [2:0] CFG_CURSOR_SHOWN       = 3'd3;
	localparam logic [2:0] CFG_CURSOR_BLINKS      = 3'd4;
	localparam logic [2:0] CFG_ADDRESS_INCREMENTS = 3'd5;
	localparam logic [2:0] CFG_DISPLAY_SHIFTS     = 3'd6;

	// byte being sent: a user byte or one command of the init sequence
	localparam logic [2:0] STEP_USER   = 3'd0;
	localparam logic [2:0] STEP_FSET   = 3'd1;
	localparam logic [2:0] STEP_FSET_X = 3'd2;
	localparam logic [2:0] STEP_DCTL   = 3'd3;
	localparam logic [2:0] STEP_CLEAR  = 3'd4;
	localparam logic [2:0] STEP_ENTRY  = 3'd5;
	localparam logic [2:0] STEP_HOME   = 3'd6;

	// pin phases of one strobe
	localparam logic [1:0] PH_SET  = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	// command bytes
	localparam logic [7:0] CMD_FSET8    = 8'b0011_0000;
	localparam logic [7:0] CMD_DCTL     = 8'b0000_1100;
	localparam logic [7:0] CMD_ENTRY    = 8'b0000_0100;
	localparam logic [7:0] CMD_FSET4    = 8'b0010_0010;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h80;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] value;
	} in_item_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_write;
		logic       enable;
		logic [7:0] bus_value;
		logic       bus_valid;
		logic       hold_after;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic       opening;
		logic [2:0] step;
		logic       low_half;
		logic [1:0] phase;
		logic       last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic four;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_OPEN = 3'b010,
		ST_XFER = 3'b100
	} state_t;

endpackage

/* hw/rtl/lcdseq_ctrl.sv */
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencer state machine: walks init steps, nibbles and strobe phases.
// ----------------------------------------------------------------------------
module lcdseq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [1:0]             in_op,
	output logic                   in_stall,
	input  lcdseq_pkg::dp_status_t status,
	output lcdseq_pkg::ctrl_cmd_t  cmd
);
	import lcdseq_pkg::*;

	state_t     state_q;
	logic [2:0] step_q;
	logic       half_q;
	logic [1:0] phase_q;
	logic       accept;
	logic       final_unit;
	logic       done_step;
	logic [2:0] step_next;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && (state_q == ST_IDLE);
	assign final_unit = !status.four || half_q;
	assign done_step  = (step_q == STEP_USER) || (step_q == STEP_HOME);

	// pick the following init command
	always_comb begin
		case (step_q)
			STEP_FSET:   step_next = status.four ? STEP_FSET_X : STEP_DCTL;
			STEP_FSET_X: step_next = STEP_DCTL;
			STEP_DCTL:   step_next = STEP_CLEAR;
			STEP_CLEAR:  step_next = STEP_ENTRY;
			STEP_ENTRY:  step_next = STEP_HOME;
			default:     step_next = STEP_HOME;
		endcase
	end

	// drive datapath commands
	always_comb begin
		cmd.load     = accept && ((in_op == OP_CMD) || (in_op == OP_DATA));
		cmd.emit     = (state_q != ST_IDLE) && status.out_free;
		cmd.opening  = (state_q == ST_OPEN);
		cmd.step     = step_q;
		cmd.low_half = half_q;
		cmd.phase    = phase_q;
		cmd.last     = (state_q == ST_XFER) && (phase_q == PH_LOW) && final_unit && done_step;
	end

	// advance state on each accepted request or emitted phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_USER;
			half_q  <= 1'b0;
			phase_q <= PH_SET;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					phase_q <= PH_SET;
					half_q  <= 1'b0;
					if (accept) begin
						if ((in_op == OP_CMD) || (in_op == OP_DATA)) begin
							step_q  <= STEP_USER;
							state_q <= ST_XFER;
						end else if (in_op == OP_INIT) begin
							state_q <= ST_OPEN;
						end
					end
				end
				ST_OPEN: begin
					if (status.out_free) begin
						step_q  <= STEP_FSET;
						half_q  <= 1'b0;
						phase_q <= PH_SET;
						state_q <= ST_XFER;
					end
				end
				ST_XFER: begin
					if (status.out_free) begin
						if (phase_q == PH_SET) begin
							phase_q <= PH_HIGH;
						end else if (phase_q == PH_HIGH) begin
							phase_q <= PH_LOW;
						end else begin
							phase_q <= PH_SET;
							if (!final_unit) begin
								half_q <= 1'b1;
							end else if (done_step) begin
								state_q <= ST_IDLE;
							end else begin
								step_q <= step_next;
								half_q <= (step_next == STEP_FSET_X);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/lcdseq_datapath.sv */
// ----------------------------------------------------------------------------
// lcdseq_datapath
// Configuration registers, byte selection and the output phase register.
// ----------------------------------------------------------------------------
module lcdseq_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [2:0]             cfg_index,
	input  logic                   cfg_data,
	input  lcdseq_pkg::in_item_t   in_data,
	input  lcdseq_pkg::ctrl_cmd_t  cmd,
	output lcdseq_pkg::dp_status_t status,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lcdseq_pkg::out_item_t  out_data
);
	import lcdseq_pkg::*;

	logic      four_q, lines_q, font_q, cursor_q, blink_q, incr_q, shift_q;
	logic [7:0] value_q;
	logic      rs_q;
	logic      out_valid_q;
	out_item_t out_q;
	logic [7:0] byte_sel;
	logic [7:0] unit_bus;
	logic      hold_end;
	logic      final_unit;
	out_item_t phase_item;

	// write configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_q   <= 1'b0;
			lines_q  <= 1'b1;
			font_q   <= 1'b0;
			cursor_q <= 1'b0;
			blink_q  <= 1'b0;
			incr_q   <= 1'b1;
			shift_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BUS_FOUR_BIT:       four_q   <= cfg_data;
				CFG_TWO_LINES:          lines_q  <= cfg_data;
				CFG_TALL_FONT:          font_q   <= cfg_data;
				CFG_CURSOR_SHOWN:       cursor_q <= cfg_data;
				CFG_CURSOR_BLINKS:      blink_q  <= cfg_data;
				CFG_ADDRESS_INCREMENTS: incr_q   <= cfg_data;
				CFG_DISPLAY_SHIFTS:     shift_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the user byte and its register select
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_data.value;
			rs_q    <= (in_data.op == OP_DATA);
		end
	end

	// select the byte of the current step
	always_comb begin
		case (cmd.step)
			STEP_USER:   byte_sel = value_q;
			STEP_FSET:   byte_sel = four_q ? CMD_FSET4
				: (CMD_FSET8 | {4'b0, lines_q, font_q, 2'b0});
			STEP_FSET_X: byte_sel = {4'b0, lines_q, font_q, 2'b0};
			STEP_DCTL:   byte_sel = CMD_DCTL | {6'b0, cursor_q, blink_q};
			STEP_CLEAR:  byte_sel = CMD_CLEAR;
			STEP_ENTRY:  byte_sel = CMD_ENTRY | {6'b0, incr_q, shift_q};
			default:     byte_sel = CMD_HOME;
		endcase
	end

	// form the pin levels of this phase
	always_comb begin
		if (!four_q) begin
			unit_bus = byte_sel;
		end else if (cmd.low_half) begin
			unit_bus = {4'b0, byte_sel[3:0]};
		end else begin
			unit_bus = {4'b0, byte_sel[7:4]};
		end
		hold_end   = (cmd.step == STEP_USER) ? 1'b0
			: ((cmd.step == STEP_FSET) ? !four_q : 1'b1);
		final_unit = !four_q || cmd.low_half;

		phase_item.read_write = 1'b0;
		phase_item.last       = cmd.last;
		if (cmd.opening) begin
			phase_item.reg_select = 1'b0;
			phase_item.enable     = 1'b0;
			phase_item.bus_value  = 8'h00;
			phase_item.bus_valid  = 1'b0;
			phase_item.hold_after = 1'b0;
		end else begin
			phase_item.reg_select = (cmd.step == STEP_USER) && rs_q;
			phase_item.enable     = (cmd.phase == PH_HIGH);
			phase_item.bus_value  = unit_bus;
			phase_item.bus_valid  = (cmd.phase == PH_SET);
			phase_item.hold_after = (cmd.phase == PH_HIGH)
				|| ((cmd.phase == PH_LOW) && final_unit && hold_end);
		end
	end

	// hold the phase until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= phase_item;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign status.four     = four_q;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

/* hw/rtl/char_lcd_bus_sequencer_top.sv */
// Character display bus sequencer, top level.
// Order: an accepted request first sets the controller state register; its
// first pin phase is then captured in the output phase register.
// Throughput: one phase per cycle while the output does not stall; a new
// request is taken only once the controller is idle after the previous one.
// Reset: arst_n clears the controller, output valid and config to defaults.
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_top
// Turns command, data and init requests into display pin phases.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lcdseq_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lcdseq_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic                  cfg_data
);
	import lcdseq_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// configuration is taken in any cycle
	assign cfg_ready = 1'b1;

	lcdseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lcdseq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
